// ===== rtl/albd_pkg.sv =====
package albd_pkg;

	// fixed field widths
	localparam int LEVEL_W    = 13;
	localparam int MARGIN_W   = 12;
	localparam int INTERVAL_W = 16;
	localparam int MANUAL_W   = 8;
	localparam int BUBBLE_W   = 32;
	localparam int TOGGLE_W   = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	// reset values and scaling
	localparam int MARGIN_RESET   = 200;
	localparam int LEVEL_RESET    = 820;
	localparam int INTERVAL_RESET = 1000;
	localparam int MANUAL_SHIFT   = 5;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INVERT   = 2'd0,
		REG_MANUAL   = 2'd1,
		REG_MARGIN   = 2'd2,
		REG_INTERVAL = 2'd3
	} reg_idx_t;

	// tags the front attaches to each queued item
	typedef struct packed {
		logic decay;       // countdown expired on this item, pull limits together
		logic pin_change;  // reed level differs from the previous item
		logic reed;        // reed level of this item
	} item_tag_t;

	// static settings seen by the back part
	typedef struct packed {
		logic                invert;
		logic [MARGIN_W-1:0] margin;
	} back_cfg_t;

	// manual threshold write event
	typedef struct packed {
		logic                en;
		logic [MANUAL_W-1:0] value;
	} manual_wr_t;

endpackage

// ===== rtl/albd_fifo.sv =====
module albd_fifo
	import albd_pkg::*;
#(
	parameter int WIDTH = 15,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             push_ready,
	input  logic             pop,
	output logic [WIDTH-1:0] head_data,
	output logic             head_valid
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != FULL_CNT);
	assign head_valid = (count_q != '0);
	assign head_data  = entry_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && head_valid;

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/albd_front.sv =====
module albd_front
	import albd_pkg::*;
#(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [SAMPLE_BITS-1:0] adc_sample,
	input  logic                  reed_level,
	input  logic [INTERVAL_W-1:0] interval,
	output logic                  push,
	input  logic                  push_ready,
	output logic [SAMPLE_BITS-1:0] push_sample,
	output item_tag_t             push_tag
);

	logic [INTERVAL_W-1:0] countdown_q;
	logic                  last_pin_q;
	logic                  accept;

	assign in_ready    = push_ready;
	assign accept      = in_valid && push_ready;
	assign push        = accept;
	assign push_sample = adc_sample;

	// classify the item: decay step and pin change
	always_comb begin
		push_tag.decay      = (countdown_q == '0);
		push_tag.pin_change = (reed_level != last_pin_q);
		push_tag.reed       = reed_level;
	end

	// decay countdown and reed history, advanced per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			countdown_q <= INTERVAL_W'(INTERVAL_RESET);
			last_pin_q  <= 1'b0;
		end else if (accept) begin
			countdown_q <= (countdown_q == '0) ? interval : countdown_q - 1'b1;
			last_pin_q  <= reed_level;
		end
	end

endmodule

// ===== rtl/albd_back.sv =====
module albd_back
	import albd_pkg::*;
#(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   head_valid,
	input  logic [SAMPLE_BITS-1:0] head_sample,
	input  item_tag_t              head_tag,
	output logic                   pop,
	input  back_cfg_t              cfg,
	input  manual_wr_t             manual_wr,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   bubble_now,
	output logic [BUBBLE_W-1:0]    bubble_total,
	output logic [TOGGLE_W-1:0]    toggle_total,
	output logic                   pin_state,
	output logic [LEVEL_W-1:0]     level_now,
	output logic [SAMPLE_BITS-1:0] peak_high,
	output logic [SAMPLE_BITS-1:0] peak_low,
	output logic                   auto_active
);

	localparam int SW = SAMPLE_BITS;
	localparam int LW = (SW > LEVEL_W) ? SW : LEVEL_W;
	localparam int EW = ((SW > MARGIN_W) ? SW : MARGIN_W) + 1;
	localparam logic [SW-1:0] SAMPLE_MAX = '1;

	logic [SW-1:0]       track_max_q;
	logic [SW-1:0]       track_min_q;
	logic [LW-1:0]       level_q;
	logic                auto_q;
	logic [BUBBLE_W-1:0] bubble_cnt_q;
	logic [TOGGLE_W-1:0] toggle_cnt_q;
	logic                pin_q;
	logic                bubble_now_q;
	logic                out_valid_q;

	logic          hit;
	logic [SW-1:0] wid_max;
	logic [SW-1:0] wid_min;
	logic [SW-1:0] mid;
	logic [LW-1:0] next_level;
	logic [EW-1:0] hi_tries;
	logic [EW-1:0] lo_tries;
	logic [EW-1:0] floor_hi;
	logic [EW-1:0] gap_hi;
	logic [EW-1:0] gap_lo;
	logic [EW-1:0] dec;
	logic [EW-1:0] inc;
	logic [SW-1:0] pulled_max;
	logic [SW-1:0] pulled_min;
	logic [SW-1:0] next_max;
	logic [SW-1:0] next_min;
	logic [LW:0]   seed_sum;
	logic [LW-1:0] seed_diff;
	logic [SW-1:0] seed_max;
	logic [SW-1:0] seed_min;

	// take the queue head whenever the output register is free or draining
	assign pop = head_valid && (!out_valid_q || out_ready);

	// classify against the old threshold, widen limits, recompute midpoint
	always_comb begin
		hit = cfg.invert ? (LW'(head_sample) >= level_q) : (LW'(head_sample) <= level_q);
		wid_max = (head_sample > track_max_q) ? head_sample : track_max_q;
		wid_min = (head_sample < track_min_q) ? head_sample : track_min_q;
		mid = {1'b0, wid_max[SW-1:1]} + {1'b0, wid_min[SW-1:1]};
		next_level = auto_q ? LW'(mid) : level_q;
	end

	// pull limits together while keeping the margin
	always_comb begin
		hi_tries = cfg.invert ? EW'(1) : EW'(3);
		lo_tries = cfg.invert ? EW'(3) : EW'(1);
		floor_hi = EW'(wid_min) + EW'(cfg.margin);
		gap_hi = '0;
		gap_lo = '0;
		if (EW'(wid_max) > floor_hi) begin
			gap_hi = EW'(wid_max) - floor_hi;
		end
		dec = (gap_hi < hi_tries) ? gap_hi : hi_tries;
		pulled_max = wid_max - SW'(dec);
		if (floor_hi < EW'(pulled_max)) begin
			gap_lo = EW'(pulled_max) - floor_hi;
		end
		inc = (gap_lo < lo_tries) ? gap_lo : lo_tries;
		pulled_min = wid_min + SW'(inc);
		next_max = head_tag.decay ? pulled_max : wid_max;
		next_min = head_tag.decay ? pulled_min : wid_min;
	end

	// reseed limits around the current threshold when auto mode is chosen
	always_comb begin
		seed_sum  = (LW+1)'(level_q) + (LW+1)'(cfg.margin);
		seed_diff = level_q - LW'(cfg.margin);
		seed_max  = (seed_sum < (LW+1)'(SAMPLE_MAX)) ? SW'(seed_sum) : SAMPLE_MAX;
		if (level_q > LW'(cfg.margin)) begin
			seed_min = (seed_diff > LW'(SAMPLE_MAX)) ? SAMPLE_MAX : SW'(seed_diff);
		end else begin
			seed_min = '0;
		end
	end

	// tracking state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_max_q  <= SAMPLE_MAX;
			track_min_q  <= '0;
			level_q      <= LW'(LEVEL_RESET);
			auto_q       <= 1'b1;
			bubble_cnt_q <= '0;
			toggle_cnt_q <= '0;
			pin_q        <= 1'b0;
		end else if (manual_wr.en) begin
			if (manual_wr.value == '0) begin
				auto_q      <= 1'b1;
				track_max_q <= seed_max;
				track_min_q <= seed_min;
			end else begin
				auto_q  <= 1'b0;
				level_q <= LW'(LEVEL_W'(manual_wr.value) << MANUAL_SHIFT);
			end
		end else if (pop) begin
			track_max_q <= next_max;
			track_min_q <= next_min;
			level_q     <= next_level;
			if (hit) begin
				bubble_cnt_q <= bubble_cnt_q + 1'b1;
			end
			if (head_tag.pin_change) begin
				toggle_cnt_q <= toggle_cnt_q + 1'b1;
				pin_q        <= head_tag.reed;
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			bubble_now_q <= hit;
		end
	end

	assign out_valid    = out_valid_q;
	assign bubble_now   = bubble_now_q;
	assign bubble_total = bubble_cnt_q;
	assign toggle_total = toggle_cnt_q;
	assign pin_state    = pin_q;
	assign level_now    = level_q[LEVEL_W-1:0];
	assign peak_high    = track_max_q;
	assign peak_low     = track_min_q;
	assign auto_active  = auto_q;

endmodule

// ===== rtl/auto_level_bubble_detector_unit.sv =====
// Auto-level bubble detector.
// Input channel (in_valid/in_ready): one sensor sample and one reed-pin level
// per transfer. Output channel (out_valid/out_ready): exactly one result per
// input, in order: bubble flag, bubble and reed-toggle counts, stored pin
// level, threshold in use and the tracked maximum and minimum.
// Throughput: one item per cycle while out_ready is held high; the front tags
// each item (decay step, pin change) and pushes it into a two-entry queue, the
// back updates the tracking state and loads the output register per item.
// A stalled receiver holds the output register; the queue then fills and
// in_ready drops after two more items, with no result lost.
// Configuration: cfg_wr_en/cfg_index/cfg_wdata, taken at once; the user must
// write only while no item is in flight, the block does not enforce it. A
// manual threshold write of zero returns to auto mode and reseeds the limits;
// a nonzero write fixes the threshold at value * 32.
// Reset (arst_n low) clears the queue and counters and restores limits
// 4095/0, threshold 820, auto mode, margin 200 and decay interval 1000.
module auto_level_bubble_detector_unit
	import albd_pkg::*;
#(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [SAMPLE_BITS-1:0] adc_sample,
	input  logic                   reed_level,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   bubble_now,
	output logic [BUBBLE_W-1:0]    bubble_total,
	output logic [TOGGLE_W-1:0]    toggle_total,
	output logic                   pin_state,
	output logic [LEVEL_W-1:0]     level_now,
	output logic [SAMPLE_BITS-1:0] peak_high,
	output logic [SAMPLE_BITS-1:0] peak_low,
	output logic                   auto_active,
	input  logic                   cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int TAG_W  = $bits(item_tag_t);
	localparam int ITEM_W = SAMPLE_BITS + TAG_W;

	logic                  invert_q;
	logic [MARGIN_W-1:0]   margin_q;
	logic [INTERVAL_W-1:0] interval_q;
	manual_wr_t            manual_wr;
	back_cfg_t             back_cfg;

	logic                   push;
	logic                   push_ready;
	logic [SAMPLE_BITS-1:0] push_sample;
	item_tag_t              push_tag;
	logic [ITEM_W-1:0]      head_data;
	logic                   head_valid;
	logic                   pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_q   <= 1'b0;
			margin_q   <= MARGIN_W'(MARGIN_RESET);
			interval_q <= INTERVAL_W'(INTERVAL_RESET);
		end else if (cfg_wr_en) begin
			case (reg_idx_t'(cfg_index))
				REG_INVERT:   invert_q   <= cfg_wdata[0];
				REG_MARGIN:   margin_q   <= cfg_wdata[MARGIN_W-1:0];
				REG_INTERVAL: interval_q <= cfg_wdata[INTERVAL_W-1:0];
				default:      ;
			endcase
		end
	end

	// manual threshold writes act on the tracking state directly
	always_comb begin
		manual_wr.en    = cfg_wr_en && (reg_idx_t'(cfg_index) == REG_MANUAL);
		manual_wr.value = cfg_wdata[MANUAL_W-1:0];
		back_cfg.invert = invert_q;
		back_cfg.margin = margin_q;
	end

	albd_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.adc_sample (adc_sample),
		.reed_level (reed_level),
		.interval   (interval_q),
		.push       (push),
		.push_ready (push_ready),
		.push_sample(push_sample),
		.push_tag   (push_tag)
	);

	albd_fifo #(
		.WIDTH(ITEM_W),
		.DEPTH(2)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_tag, push_sample}),
		.push_ready(push_ready),
		.pop       (pop),
		.head_data (head_data),
		.head_valid(head_valid)
	);

	albd_back #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_sample (head_data[SAMPLE_BITS-1:0]),
		.head_tag    (item_tag_t'(head_data[ITEM_W-1:SAMPLE_BITS])),
		.pop         (pop),
		.cfg         (back_cfg),
		.manual_wr   (manual_wr),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.bubble_now  (bubble_now),
		.bubble_total(bubble_total),
		.toggle_total(toggle_total),
		.pin_state   (pin_state),
		.level_now   (level_now),
		.peak_high   (peak_high),
		.peak_low    (peak_low),
		.auto_active (auto_active)
	);

`ifndef SYNTHESIS
	// limits never cross
	assert property (@(posedge clk) disable iff (!arst_n) peak_low <= peak_high)
		else $error("tracked minimum above tracked maximum");

	// a manual threshold is always a multiple of 32
	assert property (@(posedge clk) disable iff (!arst_n)
		!auto_active |-> (level_now[MANUAL_SHIFT-1:0] == '0))
		else $error("manual threshold not a multiple of 32");

	// the bubble count only moves by the flag of the newly loaded result
	assert property (@(posedge clk) disable iff (!arst_n)
		(bubble_total != $past(bubble_total)) |->
		(out_valid && bubble_now && (bubble_total == $past(bubble_total) + 1'b1)))
		else $error("bubble count out of step with results");
`endif

endmodule

// ===== tb/sv/bubble_detector_checker.sv =====
module bubble_detector_checker
	import albd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [11:0]           adc_sample,
	input  logic                  reed_level,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic                  bubble_now,
	input  logic [BUBBLE_W-1:0]   bubble_total,
	input  logic [TOGGLE_W-1:0]   toggle_total,
	input  logic                  pin_state,
	input  logic [LEVEL_W-1:0]    level_now,
	input  logic [11:0]           peak_high,
	input  logic [11:0]           peak_low,
	input  logic                  auto_active,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                    fail_count,
	output int                    waiting,
	output int                    checked,
	output int                    pull_steps
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FULL_SCALE = 4095;

	// one result as the block reports it
	typedef struct packed {
		logic                bubble;
		logic [BUBBLE_W-1:0] bubbles;
		logic [TOGGLE_W-1:0] toggles;
		logic                pin;
		logic [LEVEL_W-1:0]  level;
		logic [11:0]         high;
		logic [11:0]         low;
		logic                auto_on;
	} readout_t;

	// settings mirrored from the write port
	logic                  invert_on;
	logic [MARGIN_W-1:0]   margin;
	logic [INTERVAL_W-1:0] reload;

	// detector state
	logic [11:0]           hi_lim;
	logic [11:0]           lo_lim;
	logic [LEVEL_W-1:0]    level;
	logic                  auto_on;
	logic [INTERVAL_W-1:0] countdown;
	logic [BUBBLE_W-1:0]   bubbles;
	logic [TOGGLE_W-1:0]   toggles;
	logic                  pin;

	readout_t readouts_due[$];

	function automatic string show(readout_t r);
		return $sformatf(
			"bubble=%0d total=%0d toggles=%0d pin=%0d level=%0d high=%0d low=%0d auto=%0d",
			r.bubble, r.bubbles, r.toggles, r.pin, r.level, r.high, r.low, r.auto_on);
	endfunction

	// register write, applied at once
	task automatic apply_write(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		int lv;
		int mg;
		lv = level;
		mg = margin;
		case (idx)
			REG_INVERT:   invert_on = data[0];
			REG_MANUAL: begin
				if (data[MANUAL_W-1:0] == '0) begin
					// back to auto: reseed limits around the current threshold
					auto_on = 1'b1;
					hi_lim  = (lv + mg < FULL_SCALE) ? 12'(lv + mg) : 12'(FULL_SCALE);
					if (lv > mg)
						lo_lim = (lv - mg > FULL_SCALE) ? 12'(FULL_SCALE) : 12'(lv - mg);
					else
						lo_lim = '0;
				end else begin
					auto_on = 1'b0;
					level   = LEVEL_W'(data[MANUAL_W-1:0]) << MANUAL_SHIFT;
				end
			end
			REG_MARGIN:   margin = data[MARGIN_W-1:0];
			REG_INTERVAL: reload = data[INTERVAL_W-1:0];
			default:      ;
		endcase
	endtask

	// one sample through the detector
	task automatic step_detector(input logic [11:0] s, input logic r, output readout_t ro);
		int   hi_tries;
		int   lo_tries;
		logic hit;
		hit = invert_on ? (s >= level) : (s <= level);
		if (hit)
			bubbles = bubbles + 1'b1;
		if (s > hi_lim)
			hi_lim = s;
		if (s < lo_lim)
			lo_lim = s;
		if (auto_on)
			level = (hi_lim >> 1) + (lo_lim >> 1);
		// countdown expired: pull the limits toward each other, keeping the margin
		if (countdown == '0) begin
			countdown = reload;
			pull_steps++;
			hi_tries = invert_on ? 1 : 3;
			lo_tries = invert_on ? 3 : 1;
			for (int i = 0; i < hi_tries; i++)
				if (int'(hi_lim) > int'(lo_lim) + int'(margin))
					hi_lim = hi_lim - 1'b1;
			for (int i = 0; i < lo_tries; i++)
				if (int'(lo_lim) + int'(margin) < int'(hi_lim))
					lo_lim = lo_lim + 1'b1;
		end else begin
			countdown = countdown - 1'b1;
		end
		if (r != pin) begin
			toggles = toggles + 1'b1;
			pin     = r;
		end
		ro = '{hit, bubbles, toggles, pin, level, hi_lim, lo_lim, auto_on};
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		readout_t got;
		readout_t due;
		if (!arst_n) begin
			invert_on = 1'b0;
			margin    = MARGIN_W'(MARGIN_RESET);
			reload    = INTERVAL_W'(INTERVAL_RESET);
			hi_lim    = 12'(FULL_SCALE);
			lo_lim    = '0;
			level     = LEVEL_W'(LEVEL_RESET);
			auto_on   = 1'b1;
			countdown = INTERVAL_W'(INTERVAL_RESET);
			bubbles   = '0;
			toggles   = '0;
			pin       = 1'b0;
			readouts_due.delete();
			waiting   = 0;
		end else begin
			// result transfer: compare with the oldest prediction
			if (out_valid && out_ready) begin
				got = '{bubble_now, bubble_total, toggle_total, pin_state, level_now,
					peak_high, peak_low, auto_active};
				if (readouts_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: result with none predicted: %s", $time, show(got));
				end else begin
					due = readouts_due.pop_front();
					checked++;
					if (got !== due) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%0t: mismatch, expected %s", $time, show(due));
							$display("%0t:           actual   %s", $time, show(got));
						end
					end
				end
			end
			if (cfg_wr_en)
				apply_write(reg_idx_t'(cfg_index), cfg_wdata);
			// sample transfer: predict its result
			if (in_valid && in_ready) begin
				step_detector(adc_sample, reed_level, due);
				readouts_due.push_back(due);
			end
			waiting = readouts_due.size();
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import albd_pkg::*;

	localparam int FULL_SCALE  = 4095;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 235;
	localparam int CYCLE_LIMIT = 400000;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  in_valid   = 1'b0;
	logic                  in_ready;
	logic [11:0]           adc_sample = '0;
	logic                  reed_level = 1'b0;
	logic                  out_valid;
	logic                  out_ready  = 1'b0;
	logic                  bubble_now;
	logic [BUBBLE_W-1:0]   bubble_total;
	logic [TOGGLE_W-1:0]   toggle_total;
	logic                  pin_state;
	logic [LEVEL_W-1:0]    level_now;
	logic [11:0]           peak_high;
	logic [11:0]           peak_low;
	logic                  auto_active;
	logic                  cfg_wr_en  = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

	int fail_count;
	int waiting;
	int checked;
	int pull_steps;
	int items_sent;
	int long_holds;
	int cycle_count;
	int win_base;
	int win_span;
	bit hold_req;

	logic [LEVEL_W-1:0] last_level = LEVEL_W'(LEVEL_RESET);

	auto_level_bubble_detector_unit i_dut (.*);

	bubble_detector_checker i_checker (.*);

	always #5 clk = ~clk;

	// cycle limit and tracking of the threshold seen at the output
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (out_valid && out_ready)
			last_level <= level_now;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// receiver: changing stall pattern, with a long hold-off on request
	initial begin
		int rx_tick;
		int rx_mode;
		int hold_left;
		rx_tick   = 0;
		rx_mode   = 0;
		hold_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			rx_tick++;
			if (rx_tick % 97 == 0)
				rx_mode = $urandom_range(0, 4);
			if (hold_req && hold_left == 0) begin
				hold_req  = 1'b0;
				hold_left = 150;
				long_holds++;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (rx_mode)
					0:       out_ready <= 1'b1;
					1:       out_ready <= 1'($urandom_range(0, 1));
					2:       out_ready <= ($urandom_range(0, 7) != 0);
					3:       out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= (rx_tick % 4 != 0);
				endcase
			end
		end
	end

	// offer one sample and wait for its transfer
	task automatic offer(input logic [11:0] s, input logic r);
		@(negedge clk);
		in_valid   <= 1'b1;
		adc_sample <= s;
		reed_level <= r;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic pause(input int n);
		repeat (n) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	// drain all outstanding results before touching the registers
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (waiting != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input int value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CFG_DATA_W'(value);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// extremes, values near the current threshold, or the phase's window
	function automatic logic [11:0] pick_sample();
		int v;
		case ($urandom_range(0, 9))
			0:       v = 0;
			1:       v = FULL_SCALE;
			2, 3:    v = int'(last_level) + int'($urandom_range(0, 6)) - 3;
			default: v = win_base + int'($urandom_range(0, win_span));
		endcase
		if (v < 0)
			v = 0;
		if (v > FULL_SCALE)
			v = FULL_SCALE;
		return 12'(v);
	endfunction

	initial begin
		int burst;
		int n;
		int margin_val;
		int interval_val;
		int manual_val;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings, auto mode, sample extremes
		offer(12'd0, 1'b1);
		offer(12'd4095, 1'b0);
		offer(12'd2048, 1'b1);
		offer(12'd1, 1'b0);
		offer(12'd4094, 1'b1);

		// inverted polarity
		settle();
		write_reg(REG_INVERT, 1);
		offer(12'd4095, 1'b1);
		offer(12'd0, 1'b0);
		offer(12'd2047, 1'b1);

		// highest manual threshold, above the sample range
		settle();
		write_reg(REG_MANUAL, 255);
		offer(12'd4095, 1'b0);
		offer(12'd0, 1'b1);
		settle();
		write_reg(REG_INVERT, 0);
		offer(12'd4095, 1'b1);

		// reseed from the high manual level with the widest margin
		settle();
		write_reg(REG_MARGIN, 4095);
		write_reg(REG_MANUAL, 0);
		offer(12'd4000, 1'b0);
		offer(12'd4095, 1'b1);

		// lowest manual threshold, samples on both sides of it
		settle();
		write_reg(REG_MARGIN, 0);
		write_reg(REG_MANUAL, 1);
		offer(12'd32, 1'b0);
		offer(12'd33, 1'b1);
		offer(12'd31, 1'b0);

		// zero interval, reseed around a low threshold with no margin
		settle();
		write_reg(REG_INTERVAL, 0);
		write_reg(REG_MANUAL, 0);
		offer(12'd32, 1'b1);
		offer(12'd0, 1'b0);
		offer(12'd4095, 1'b1);

		// random phases; the first reload of the countdown falls in phase 4
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				1, 5:    margin_val = 0;
				3:       margin_val = 4095;
				default: margin_val = $urandom_range(0, 400);
			endcase
			case (ph)
				0:       interval_val = 17;
				1:       interval_val = 65535;
				2:       interval_val = 2;
				3:       interval_val = 40;
				5:       interval_val = $urandom_range(0, 12);
				7:       interval_val = $urandom_range(1, 6);
				default: interval_val = 0;
			endcase
			case (ph)
				2:       manual_val = $urandom_range(1, 254);
				4:       manual_val = 255;
				6:       manual_val = 1;
				default: manual_val = 0;
			endcase
			win_base = $urandom_range(0, FULL_SCALE);
			if ($urandom_range(0, 3) == 0)
				win_span = FULL_SCALE - win_base;
			else
				win_span = $urandom_range(0, 600);

			settle();
			write_reg(REG_INVERT, ph % 2);
			write_reg(REG_MARGIN, margin_val);
			write_reg(REG_INTERVAL, interval_val);
			write_reg(REG_MANUAL, manual_val);

			n = 0;
			while (n < PHASE_ITEMS) begin
				burst = $urandom_range(1, 24);
				for (int b = 0; b < burst && n < PHASE_ITEMS; b++) begin
					offer(pick_sample(), 1'($urandom_range(0, 1)));
					n++;
					if (n == 40)
						hold_req = 1'b1;
				end
				if ($urandom_range(0, 3) != 0)
					pause($urandom_range(1, 12));
			end
		end

		// drain and let the pipeline run out
		@(negedge clk);
		in_valid <= 1'b0;
		while (waiting != 0)
			@(negedge clk);
		repeat (5) @(negedge clk);

		$display("run covered %0d samples over %0d random setting phases, %0d results compared",
			items_sent, PHASES, checked);
		$display("limit pull-together steps: %0d, long receiver hold-offs: %0d",
			pull_steps, long_holds);
		if (fail_count == 0 && waiting == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
